/* rtl/lsrc_pkg.sv */
// Shared types and constants of the line segment rectangle clipper.
package lsrc_pkg;

   localparam int CoordBits = 16;
   localparam int DeltaBits = CoordBits + 1;
   localparam int ProdBits  = 2 * DeltaBits;
   localparam int RemBits   = 2 * CoordBits;
   localparam int Lanes     = 4;

   localparam logic signed [CoordBits-1:0] RectLeftReset   = CoordBits'(0);
   localparam logic signed [CoordBits-1:0] RectTopReset    = CoordBits'(0);
   localparam logic signed [CoordBits-1:0] RectRightReset  = CoordBits'(479);
   localparam logic signed [CoordBits-1:0] RectBottomReset = CoordBits'(799);

   typedef enum logic [1:0] {
      CSR_RECT_LEFT   = 2'd0,
      CSR_RECT_TOP    = 2'd1,
      CSR_RECT_RIGHT  = 2'd2,
      CSR_RECT_BOTTOM = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] start_x;
      logic signed [CoordBits-1:0] start_y;
      logic signed [CoordBits-1:0] end_x;
      logic signed [CoordBits-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic                        visible;
      logic signed [CoordBits-1:0] clip_start_x;
      logic signed [CoordBits-1:0] clip_start_y;
      logic signed [CoordBits-1:0] clip_end_x;
      logic signed [CoordBits-1:0] clip_end_y;
   } rsp_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] sx;
      logic signed [CoordBits-1:0] sy;
      logic signed [CoordBits-1:0] ex;
      logic signed [CoordBits-1:0] ey;
      logic signed [DeltaBits-1:0] dx;
      logic signed [DeltaBits-1:0] dy;
   } seg_type;

   // Entry (t0) and exit (t1) parameters as fractions, denominators positive.
   typedef struct packed {
      logic signed [DeltaBits-1:0] t0n;
      logic signed [DeltaBits-1:0] t0d;
      logic signed [DeltaBits-1:0] t1n;
      logic signed [DeltaBits-1:0] t1d;
      logic                        vis;
   } frac_type;

   localparam frac_type FracInit = '{
      t0n: DeltaBits'(0), t0d: DeltaBits'(1),
      t1n: DeltaBits'(1), t1d: DeltaBits'(1),
      vis: 1'b1
   };

   typedef struct packed {
      logic [RemBits-1:0]   rem;
      logic [CoordBits-1:0] den;
      logic [CoordBits-1:0] quot;
      logic                 neg;
   } div_lane_type;

   // Lanes: t0*dx, t0*dy, t1*dx, t1*dy.
   typedef struct packed {
      seg_type                        seg;
      logic                           vis;
      div_lane_type [Lanes-1:0]       lane;
   } div_stage_type;

endpackage

/* rtl/lsrc_bound_cell.sv */
// One clip boundary: forms p and q, cross-multiplies, then raises t0, lowers t1, or drops a parallel segment outside.
module lsrc_bound_cell #(
   parameter int unsigned BOUND = 0
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  lsrc_pkg::seg_type                       in_seg,
   input  lsrc_pkg::frac_type                      in_frac,
   input  logic signed [lsrc_pkg::CoordBits-1:0]   bound_val,
   output logic                                    out_valid,
   output lsrc_pkg::seg_type                       out_seg,
   output lsrc_pkg::frac_type                      out_frac
);

   localparam int Db = lsrc_pkg::DeltaBits;
   localparam int Pb = lsrc_pkg::ProdBits;
   localparam bit UseX    = BOUND < 2;
   localparam bit LowSide = (BOUND % 2) == 0;

   logic signed [Db-1:0] dsel;
   logic signed [Db-1:0] ssel;
   logic signed [Db-1:0] p;
   logic signed [Db-1:0] q;
   logic signed [Db-1:0] rn;
   logic signed [Db-1:0] rd;
   logic                 pneg;
   logic signed [Pb-1:0] lhs;
   logic signed [Pb-1:0] rhs;

   logic                 a_valid_ff;
   lsrc_pkg::seg_type    a_seg_ff;
   lsrc_pkg::frac_type   a_frac_ff;
   logic                 a_pneg_ff;
   logic                 a_pzero_ff;
   logic                 a_qneg_ff;
   logic signed [Db-1:0] a_rn_ff;
   logic signed [Db-1:0] a_rd_ff;
   logic signed [Pb-1:0] a_lhs_ff;
   logic signed [Pb-1:0] a_rhs_ff;

   logic                 b_valid_ff;
   lsrc_pkg::seg_type    b_seg_ff;
   lsrc_pkg::frac_type   b_frac_in;
   lsrc_pkg::frac_type   b_frac_ff;

   always_comb begin
      dsel = UseX ? in_seg.dx : in_seg.dy;
      ssel = UseX ? Db'(in_seg.sx) : Db'(in_seg.sy);
      if (LowSide) begin
         p = -dsel;
         q = ssel - Db'(bound_val);
      end else begin
         p = dsel;
         q = Db'(bound_val) - ssel;
      end
      pneg = p[Db-1];
      rn   = pneg ? -q : q;
      rd   = pneg ? -p : p;
      lhs  = Pb'(rn) * Pb'(pneg ? in_frac.t0d : in_frac.t1d);
      rhs  = Pb'(pneg ? in_frac.t0n : in_frac.t1n) * Pb'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_seg_ff   <= in_seg;
         a_frac_ff  <= in_frac;
         a_pneg_ff  <= pneg;
         a_pzero_ff <= (p == '0);
         a_qneg_ff  <= q[Db-1];
         a_rn_ff    <= rn;
         a_rd_ff    <= rd;
         a_lhs_ff   <= lhs;
         a_rhs_ff   <= rhs;
         b_seg_ff   <= a_seg_ff;
         b_frac_ff  <= b_frac_in;
      end
   end

   // Parallel boundary: drop the segment if it starts outside.
   always_comb begin
      b_frac_in = a_frac_ff;
      if (a_pzero_ff) begin
         if (a_qneg_ff) b_frac_in.vis = 1'b0;
      end else if (a_pneg_ff) begin
         if (a_lhs_ff > a_rhs_ff) begin
            b_frac_in.t0n = a_rn_ff;
            b_frac_in.t0d = a_rd_ff;
         end
      end else if (a_lhs_ff < a_rhs_ff) begin
         b_frac_in.t1n = a_rn_ff;
         b_frac_in.t1d = a_rd_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_seg   = b_seg_ff;
   assign out_frac  = b_frac_ff;

endmodule

/* rtl/lsrc_div_cell.sv */
// One restoring-division step: resolves one quotient bit for all four lanes.
module lsrc_div_cell #(
   parameter int unsigned BIT = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  lsrc_pkg::div_stage_type in_stage,
   output logic                    out_valid,
   output lsrc_pkg::div_stage_type out_stage
);

   localparam int Rb = lsrc_pkg::RemBits;

   lsrc_pkg::div_stage_type step;
   logic [Rb-1:0]           trial [lsrc_pkg::Lanes];
   logic                    out_valid_ff;
   lsrc_pkg::div_stage_type out_stage_ff;

   always_comb begin
      step = in_stage;
      for (int j = 0; j < lsrc_pkg::Lanes; j++) begin
         trial[j] = Rb'(in_stage.lane[j].den) << BIT;
         if (in_stage.lane[j].rem >= trial[j]) begin
            step.lane[j].rem       = in_stage.lane[j].rem - trial[j];
            step.lane[j].quot[BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) out_stage_ff <= step;
   end

   assign out_valid = out_valid_ff;
   assign out_stage = out_stage_ff;

endmodule

/* rtl/line_segment_rect_clipper_core.sv */
// Throughput: one segment per cycle while the skid entry is empty; the row of one-bit divider cells sets the depth.
// A result waiting at the output does not block input until the skid entry fills.
// Reset (synchronous) empties the pipeline and loads the rectangle 0,0 .. 479,799.
module line_segment_rect_clipper_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  lsrc_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output lsrc_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write_en,
   input  lsrc_pkg::csr_index_type            csr_index,
   input  logic [lsrc_pkg::CoordBits-1:0]     csr_wdata
);

   localparam int Cb = lsrc_pkg::CoordBits;
   localparam int Db = lsrc_pkg::DeltaBits;
   localparam int Pb = lsrc_pkg::ProdBits;
   localparam int Rb = lsrc_pkg::RemBits;
   localparam int Vb = Cb + 2;
   localparam int Ln = lsrc_pkg::Lanes;

   logic signed [Cb-1:0] rect_left_ff;
   logic signed [Cb-1:0] rect_top_ff;
   logic signed [Cb-1:0] rect_right_ff;
   logic signed [Cb-1:0] rect_bottom_ff;
   logic signed [Cb-1:0] bound_val [4];

   logic en;

   logic                    in_valid_ff;
   lsrc_pkg::seg_type       in_seg_in;
   lsrc_pkg::seg_type       in_seg_ff;

   logic                    bnd_valid [5];
   lsrc_pkg::seg_type       bnd_seg   [5];
   lsrc_pkg::frac_type      bnd_frac  [5];

   logic                    m_valid_ff;
   lsrc_pkg::seg_type       m_seg_ff;
   lsrc_pkg::frac_type      m_frac_ff;
   logic signed [Pb-1:0]    m_cmp_a_in;
   logic signed [Pb-1:0]    m_cmp_b_in;
   logic signed [Pb-1:0]    m_cmp_a_ff;
   logic signed [Pb-1:0]    m_cmp_b_ff;
   logic signed [Pb-1:0]    m_prod_in [Ln];
   logic signed [Pb-1:0]    m_prod_ff [Ln];

   logic                    c_valid_ff;
   lsrc_pkg::div_stage_type c_stage_in;
   lsrc_pkg::div_stage_type c_stage_ff;
   logic signed [Db-1:0]    c_den;
   logic signed [Pb-1:0]    c_mag;

   logic                    div_valid [Cb+1];
   lsrc_pkg::div_stage_type div_stage [Cb+1];

   lsrc_pkg::div_stage_type fin_stage;
   lsrc_pkg::rsp_type       fin_data;
   logic                    push;
   logic                    pop;

   logic                    out_valid_ff;
   logic                    out_valid_in;
   lsrc_pkg::rsp_type       out_data_ff;
   lsrc_pkg::rsp_type       out_data_in;
   logic                    skid_valid_ff;
   logic                    skid_valid_in;
   lsrc_pkg::rsp_type       skid_data_ff;
   lsrc_pkg::rsp_type       skid_data_in;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rect_left_ff   <= lsrc_pkg::RectLeftReset;
         rect_top_ff    <= lsrc_pkg::RectTopReset;
         rect_right_ff  <= lsrc_pkg::RectRightReset;
         rect_bottom_ff <= lsrc_pkg::RectBottomReset;
      end else if (csr_write_en) begin
         case (csr_index)
            lsrc_pkg::CSR_RECT_LEFT:   rect_left_ff   <= csr_wdata;
            lsrc_pkg::CSR_RECT_TOP:    rect_top_ff    <= csr_wdata;
            lsrc_pkg::CSR_RECT_RIGHT:  rect_right_ff  <= csr_wdata;
            lsrc_pkg::CSR_RECT_BOTTOM: rect_bottom_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign bound_val[0] = rect_left_ff;
   assign bound_val[1] = rect_right_ff;
   assign bound_val[2] = rect_top_ff;
   assign bound_val[3] = rect_bottom_ff;

   // The whole pipeline holds only while the skid entry is occupied.
   assign en        = !skid_valid_ff;
   assign req_ready = en;

   always_comb begin
      in_seg_in.sx = req_data.start_x;
      in_seg_in.sy = req_data.start_y;
      in_seg_in.ex = req_data.end_x;
      in_seg_in.ey = req_data.end_y;
      in_seg_in.dx = Db'(req_data.end_x) - Db'(req_data.start_x);
      in_seg_in.dy = Db'(req_data.end_y) - Db'(req_data.start_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) in_seg_ff <= in_seg_in;
   end

   assign bnd_valid[0] = in_valid_ff;
   assign bnd_seg[0]   = in_seg_ff;
   assign bnd_frac[0]  = lsrc_pkg::FracInit;

   for (genvar b = 0; b < 4; b++) begin : g_bound
      lsrc_bound_cell #(.BOUND(b)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (bnd_valid[b]),
         .in_seg    (bnd_seg[b]),
         .in_frac   (bnd_frac[b]),
         .bound_val (bound_val[b]),
         .out_valid (bnd_valid[b+1]),
         .out_seg   (bnd_seg[b+1]),
         .out_frac  (bnd_frac[b+1])
      );
   end

   // Interval check and numerators of the four endpoint offsets
   always_comb begin
      m_cmp_a_in   = Pb'(bnd_frac[4].t0n) * Pb'(bnd_frac[4].t1d);
      m_cmp_b_in   = Pb'(bnd_frac[4].t1n) * Pb'(bnd_frac[4].t0d);
      m_prod_in[0] = Pb'(bnd_frac[4].t0n) * Pb'(bnd_seg[4].dx);
      m_prod_in[1] = Pb'(bnd_frac[4].t0n) * Pb'(bnd_seg[4].dy);
      m_prod_in[2] = Pb'(bnd_frac[4].t1n) * Pb'(bnd_seg[4].dx);
      m_prod_in[3] = Pb'(bnd_frac[4].t1n) * Pb'(bnd_seg[4].dy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= bnd_valid[4];
         c_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_seg_ff   <= bnd_seg[4];
         m_frac_ff  <= bnd_frac[4];
         m_cmp_a_ff <= m_cmp_a_in;
         m_cmp_b_ff <= m_cmp_b_in;
         for (int j = 0; j < Ln; j++) m_prod_ff[j] <= m_prod_in[j];
         c_stage_ff <= c_stage_in;
      end
   end

   // Round half away from zero: divide |n| + floor(d/2) and restore the sign.
   always_comb begin
      c_stage_in.seg = m_seg_ff;
      c_stage_in.vis = m_frac_ff.vis && !(m_cmp_a_ff > m_cmp_b_ff);
      c_den = '0;
      c_mag = '0;
      for (int j = 0; j < Ln; j++) begin
         c_den = (j < 2) ? m_frac_ff.t0d : m_frac_ff.t1d;
         c_mag = m_prod_ff[j][Pb-1] ? -m_prod_ff[j] : m_prod_ff[j];
         c_stage_in.lane[j].rem  = Rb'(c_mag) + Rb'(c_den[Cb-1:1]);
         c_stage_in.lane[j].den  = c_den[Cb-1:0];
         c_stage_in.lane[j].quot = '0;
         c_stage_in.lane[j].neg  = m_prod_ff[j][Pb-1];
      end
   end

   assign div_valid[0] = c_valid_ff;
   assign div_stage[0] = c_stage_ff;

   for (genvar i = 0; i < Cb; i++) begin : g_div
      lsrc_div_cell #(.BIT(Cb - 1 - i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_valid[i]),
         .in_stage  (div_stage[i]),
         .out_valid (div_valid[i+1]),
         .out_stage (div_stage[i+1])
      );
   end

   function automatic logic signed [Cb-1:0] place_coord(
      input lsrc_pkg::div_lane_type ln,
      input logic signed [Cb-1:0]   base,
      input logic signed [Cb-1:0]   lo,
      input logic signed [Cb-1:0]   hi
   );
      logic signed [Vb-1:0] qv;
      logic signed [Vb-1:0] val;
      qv  = signed'({2'b00, ln.quot});
      if (ln.neg) qv = -qv;
      val = Vb'(base) + qv;
      if (val < Vb'(lo)) return lo;
      else if (val > Vb'(hi)) return hi;
      else return val[Cb-1:0];
   endfunction

   always_comb begin
      fin_stage = div_stage[Cb];
      if (fin_stage.vis) begin
         fin_data.visible      = 1'b1;
         fin_data.clip_start_x = place_coord(fin_stage.lane[0], fin_stage.seg.sx,
                                             rect_left_ff, rect_right_ff);
         fin_data.clip_start_y = place_coord(fin_stage.lane[1], fin_stage.seg.sy,
                                             rect_top_ff, rect_bottom_ff);
         fin_data.clip_end_x   = place_coord(fin_stage.lane[2], fin_stage.seg.sx,
                                             rect_left_ff, rect_right_ff);
         fin_data.clip_end_y   = place_coord(fin_stage.lane[3], fin_stage.seg.sy,
                                             rect_top_ff, rect_bottom_ff);
      end else begin
         fin_data.visible      = 1'b0;
         fin_data.clip_start_x = fin_stage.seg.sx;
         fin_data.clip_start_y = fin_stage.seg.sy;
         fin_data.clip_end_x   = fin_stage.seg.ex;
         fin_data.clip_end_y   = fin_stage.seg.ey;
      end
   end

   // Output register with one skid entry
   assign push = en && div_valid[Cb];
   assign pop  = out_valid_ff && rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = fin_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = fin_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry occupied while output register empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ready))
      else $error("skid entry filled without an output stall");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !out_valid_ff && !skid_valid_ff && !in_valid_ff)
      else $error("pipeline not empty after reset");

endmodule
